// File: rtl/uer_pkg.sv
// ============================================================================
// uer_pkg
// Shared constants, register codes and types of the ultrasonic echo ranger.
// ============================================================================
package uer_pkg;

    // Configuration register widths and reset values.
    localparam int CFG_W     = 17;
    localparam int DIST_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0]  RISE_TIMEOUT_RST = CFG_W'(100000);
    localparam logic [CFG_W-1:0]  FALL_TIMEOUT_RST = CFG_W'(100000);
    localparam logic [CFG_W-1:0]  MAX_ECHO_RST     = CFG_W'(38000);
    localparam logic [DIST_W-1:0] FAR_VALUE_RST    = DIST_W'(5);

    // Largest distance that fits the result field.
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Default timing parameters.
    localparam int DEF_SETTLE_TICKS  = 2;
    localparam int DEF_TRIGGER_TICKS = 10;
    localparam int DEF_TIMER_BITS    = 17;

    // Distance scale: width * 34 / 2000, kept as the reduced fraction 17 / 1000.
    localparam int DIST_NUM = 17;
    localparam int DIST_DEN = 1000;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RISE_TIMEOUT = 2'd0,
        REG_FALL_TIMEOUT = 2'd1,
        REG_MAX_ECHO     = 2'd2,
        REG_FAR_VALUE    = 2'd3
    } cfg_reg_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_NO_ECHO = 2'd1,
        ST_FAR     = 2'd2
    } status_t;

    // Control part of one result, handed from the sequencer to the output stage.
    typedef struct packed {
        logic    trigger;
        logic    busy;
        logic    done;
        status_t status;
    } res_ctrl_t;

endpackage

// File: rtl/uer_cfg_regs.sv
// ============================================================================
// uer_cfg_regs
// Configuration register file: timeouts, out-of-range width and far value.
// ============================================================================
module uer_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]     cfg_data,
    output logic [uer_pkg::CFG_W-1:0]     rise_timeout,
    output logic [uer_pkg::CFG_W-1:0]     fall_timeout,
    output logic [uer_pkg::CFG_W-1:0]     max_echo,
    output logic [uer_pkg::DIST_W-1:0]    far_value
);
    import uer_pkg::*;

    logic [CFG_W-1:0]  rise_timeout_reg;
    logic [CFG_W-1:0]  fall_timeout_reg;
    logic [CFG_W-1:0]  max_echo_reg;
    logic [DIST_W-1:0] far_value_reg;

    // Register writes, one register per enabled cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_timeout_reg <= RISE_TIMEOUT_RST;
            fall_timeout_reg <= FALL_TIMEOUT_RST;
            max_echo_reg     <= MAX_ECHO_RST;
            far_value_reg    <= FAR_VALUE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RISE_TIMEOUT: rise_timeout_reg <= cfg_data;
                REG_FALL_TIMEOUT: fall_timeout_reg <= cfg_data;
                REG_MAX_ECHO:     max_echo_reg     <= cfg_data;
                REG_FAR_VALUE:    far_value_reg    <= cfg_data[DIST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign rise_timeout = rise_timeout_reg;
    assign fall_timeout = fall_timeout_reg;
    assign max_echo     = max_echo_reg;
    assign far_value    = far_value_reg;

endmodule

// File: rtl/uer_seq.sv
// ============================================================================
// uer_seq
// Measurement sequencer: settle, trigger pulse, wait for the echo rise and
// time the echo width. Registers the control part and the width of each accepted tick's result.
// ============================================================================
module uer_seq
#(
    parameter int SETTLE_TICKS  = uer_pkg::DEF_SETTLE_TICKS,
    parameter int TRIGGER_TICKS = uer_pkg::DEF_TRIGGER_TICKS,
    parameter int TIMER_BITS    = uer_pkg::DEF_TIMER_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      start_req,
    input  logic                      echo,
    input  logic [uer_pkg::CFG_W-1:0] rise_timeout,
    input  logic [uer_pkg::CFG_W-1:0] fall_timeout,
    input  logic [uer_pkg::CFG_W-1:0] max_echo,
    output uer_pkg::res_ctrl_t        res_ctrl,
    output logic [TIMER_BITS-1:0]     res_width
);
    import uer_pkg::*;

    // Compare width that holds both a counter and a configuration value.
    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;
    localparam logic [TIMER_BITS-1:0] CNT_ONE = TIMER_BITS'(1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    phase_t                phase_reg,  phase_next;
    logic [TIMER_BITS-1:0] timer_reg,  timer_next;
    logic [TIMER_BITS-1:0] width_reg,  width_next;
    res_ctrl_t             ctrl_reg,   ctrl_next;
    logic [TIMER_BITS-1:0] rwidth_reg, rwidth_next;

    phase_t                phase_cur;
    logic [TIMER_BITS-1:0] timer_cur;
    logic [TIMER_BITS-1:0] width_cur;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [TIMER_BITS-1:0] width_inc;
    logic                  report_en;
    logic [TIMER_BITS-1:0] report_w;

    // A start request while idle enters the settle phase on the same tick.
    always_comb
    begin
        if (phase_reg == PH_IDLE && start_req)
        begin
            phase_cur = PH_SETTLE;
            timer_cur = '0;
            width_cur = '0;
        end
        else
        begin
            phase_cur = phase_reg;
            timer_cur = timer_reg;
            width_cur = width_reg;
        end
    end

    // Saturating counter steps.
    assign timer_inc = (timer_cur == CNT_MAX) ? CNT_MAX : timer_cur + CNT_ONE;
    assign width_inc = (width_cur == CNT_MAX) ? CNT_MAX : width_cur + CNT_ONE;

    // Next state and result of one tick.
    always_comb
    begin
        phase_next     = phase_cur;
        timer_next     = timer_cur;
        width_next     = width_cur;
        ctrl_next      = '0;
        ctrl_next.status = ST_VALID;
        rwidth_next    = width_cur;
        report_en      = 1'b0;
        report_w       = width_cur;

        case (phase_cur)
            PH_IDLE:
            begin
            end
            PH_SETTLE:
            begin
                ctrl_next.busy = 1'b1;
                if (timer_inc >= TIMER_BITS'(SETTLE_TICKS))
                begin
                    phase_next = PH_TRIG;
                    timer_next = '0;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            PH_TRIG:
            begin
                ctrl_next.busy    = 1'b1;
                ctrl_next.trigger = 1'b1;
                if (timer_inc >= TIMER_BITS'(TRIGGER_TICKS))
                begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
                else
                begin
                    timer_next = timer_inc;
                end
            end
            PH_WAIT:
            begin
                ctrl_next.busy = 1'b1;
                if (echo)
                begin
                    // The rise tick is the first high tick of the width.
                    phase_next = PH_MEAS;
                    width_next = CNT_ONE;
                    timer_next = CNT_ONE;
                    if (CW'(CNT_ONE) >= CW'(fall_timeout) || CNT_ONE == CNT_MAX)
                    begin
                        report_en = 1'b1;
                        report_w  = CNT_ONE;
                    end
                end
                else
                begin
                    timer_next = timer_inc;
                    if (CW'(timer_inc) >= CW'(rise_timeout) || timer_inc == CNT_MAX)
                    begin
                        phase_next       = PH_IDLE;
                        timer_next       = '0;
                        width_next       = '0;
                        ctrl_next.busy   = 1'b0;
                        ctrl_next.done   = 1'b1;
                        ctrl_next.status = ST_NO_ECHO;
                    end
                end
            end
            PH_MEAS:
            begin
                ctrl_next.busy = 1'b1;
                if (!echo)
                begin
                    report_en = 1'b1;
                    report_w  = width_cur;
                end
                else
                begin
                    width_next = width_inc;
                    timer_next = width_inc;
                    if (CW'(width_inc) >= CW'(fall_timeout) || width_inc == CNT_MAX)
                    begin
                        report_en = 1'b1;
                        report_w  = width_inc;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        endcase

        // End of the echo, fall timeout or width saturation: classify the width and go back to idle.
        if (report_en)
        begin
            phase_next       = PH_IDLE;
            timer_next       = '0;
            ctrl_next.busy   = 1'b0;
            ctrl_next.done   = 1'b1;
            ctrl_next.status = (CW'(report_w) >= CW'(max_echo)) ? ST_FAR : ST_VALID;
            rwidth_next      = report_w;
        end
    end

    // Sequencer state and result registers, updated per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            width_reg  <= '0;
            ctrl_reg   <= '0;
            rwidth_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            width_reg  <= width_next;
            ctrl_reg   <= ctrl_next;
            rwidth_reg <= rwidth_next;
        end
    end

    assign res_ctrl  = ctrl_reg;
    assign res_width = rwidth_reg;

endmodule

// File: rtl/uer_dist.sv
// ============================================================================
// uer_dist
// Output stage: converts the echo width to centimeters with a reciprocal
// multiply, selects the reported distance and holds the result register.
// ============================================================================
module uer_dist
#(
    parameter int TIMER_BITS = uer_pkg::DEF_TIMER_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  uer_pkg::res_ctrl_t         in_ctrl,
    input  logic [TIMER_BITS-1:0]      in_width,
    input  logic [uer_pkg::DIST_W-1:0] far_value,
    output logic                       out_valid,
    output uer_pkg::res_ctrl_t         out_ctrl,
    output logic [uer_pkg::DIST_W-1:0] out_distance
);
    import uer_pkg::*;

    // floor(w * 17 / 1000) == (w * RECIP) >> SHIFT for every w below 2^TIMER_BITS,
    // since 2^SHIFT exceeds 1000 * 2^TIMER_BITS.
    localparam int SHIFT = TIMER_BITS + 10;
    localparam int RW    = TIMER_BITS + 5;
    localparam int PW    = TIMER_BITS + RW;
    localparam int QW    = PW - SHIFT;
    localparam int XW    = QW + DIST_W;
    localparam longint unsigned RECIP_L =
        (longint'(DIST_NUM) * (64'd1 << SHIFT) + longint'(DIST_DEN) - 1) / longint'(DIST_DEN);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    logic [PW-1:0]     prod;
    logic [QW-1:0]     quot;
    logic [XW-1:0]     quot_ext;
    logic [DIST_W-1:0] dist_sat;
    logic [DIST_W-1:0] dist_next;

    logic              valid_reg;
    res_ctrl_t         ctrl_reg;
    logic [DIST_W-1:0] dist_reg;

    // Width to centimeters, saturated to the field range.
    assign prod     = PW'(in_width) * PW'(RECIP);
    assign quot     = prod[PW-1:SHIFT];
    assign quot_ext = XW'(quot);
    assign dist_sat = (quot_ext > XW'(DIST_MAX)) ? DIST_MAX : quot_ext[DIST_W-1:0];

    // Distance shown only on a done tick.
    always_comb
    begin
        dist_next = '0;
        if (in_ctrl.done)
        begin
            case (in_ctrl.status)
                ST_VALID:   dist_next = dist_sat;
                ST_FAR:     dist_next = far_value;
                ST_NO_ECHO: dist_next = '0;
                default:    dist_next = '0;
            endcase
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctrl_reg <= in_ctrl;
            dist_reg <= dist_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_ctrl     = ctrl_reg;
    assign out_distance = dist_reg;

endmodule

// File: rtl/ultrasonic_echo_ranger.sv
// ============================================================================
// ultrasonic_echo_ranger
// Pipeline: an accepted tick passes through two registered stages, the sequencer
// state update and then the distance multiply, before its result shows on m_tvalid.
// Throughput: one tick per cycle; both stages advance together and stall
// only while the output register holds a result that is not taken.
// Reset (rst_n, asynchronous): sequencer idle, counters zero, pipeline empty,
// configuration back to its default values.
// ============================================================================
module ultrasonic_echo_ranger
#(
    parameter int SETTLE_TICKS  = uer_pkg::DEF_SETTLE_TICKS,
    parameter int TRIGGER_TICKS = uer_pkg::DEF_TRIGGER_TICKS,
    parameter int TIMER_BITS    = uer_pkg::DEF_TIMER_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Per-tick input transaction.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [uer_pkg::IN_TDATA_W-1:0] s_tdata,  // [0] start_req, [1] echo
    // Per-tick result transaction.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [uer_pkg::OUT_TDATA_W-1:0] m_tdata, // [0] trigger, [1] busy_res,
                                                     // [2] done_res, [4:3] status,
                                                     // [16:5] distance_cm
    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]      cfg_data
);
    import uer_pkg::*;

    logic [CFG_W-1:0]      rise_timeout;
    logic [CFG_W-1:0]      fall_timeout;
    logic [CFG_W-1:0]      max_echo;
    logic [DIST_W-1:0]     far_value;

    logic                  adv;
    logic                  accept;
    logic                  s1_valid_reg;
    res_ctrl_t             s1_ctrl;
    logic [TIMER_BITS-1:0] s1_width;
    res_ctrl_t             out_ctrl;
    logic [DIST_W-1:0]     out_distance;

    // Pipeline advances whenever the output register is empty or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    uer_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rise_timeout (rise_timeout),
        .fall_timeout (fall_timeout),
        .max_echo     (max_echo),
        .far_value    (far_value)
    );

    uer_seq
    #(
        .SETTLE_TICKS  (SETTLE_TICKS),
        .TRIGGER_TICKS (TRIGGER_TICKS),
        .TIMER_BITS    (TIMER_BITS)
    )
    u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .start_req    (s_tdata[0]),
        .echo         (s_tdata[1]),
        .rise_timeout (rise_timeout),
        .fall_timeout (fall_timeout),
        .max_echo     (max_echo),
        .res_ctrl     (s1_ctrl),
        .res_width    (s1_width)
    );

    // Valid flag of the sequencer result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    uer_dist
    #(
        .TIMER_BITS (TIMER_BITS)
    )
    u_dist
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s1_valid_reg),
        .in_ctrl      (s1_ctrl),
        .in_width     (s1_width),
        .far_value    (far_value),
        .out_valid    (m_tvalid),
        .out_ctrl     (out_ctrl),
        .out_distance (out_distance)
    );

    // Result packing.
    assign m_tdata = OUT_TDATA_W'({out_distance, out_ctrl.status, out_ctrl.done,
                                   out_ctrl.busy, out_ctrl.trigger});

    // A done tick always ends the measurement.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_ctrl.done |-> !out_ctrl.busy)
        else $error("done result reported while still busy");

    // The trigger pulse only happens inside a measurement.
    a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_ctrl.trigger |-> out_ctrl.busy && !out_ctrl.done)
        else $error("trigger driven outside a measurement");

    // Non-done results carry a zero status and distance.
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_ctrl.done |-> out_ctrl.status == ST_VALID && out_distance == '0)
        else $error("status or distance set on a tick that is not done");

    // No echo rise reports a zero distance.
    a_no_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_ctrl.done && out_ctrl.status == ST_NO_ECHO |-> out_distance == '0)
        else $error("no-echo result with nonzero distance");

    // A stalled result blocks new input transactions.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the result register is stalled");

endmodule
